/* rtl/core/qpr_pkg.sv */
// Shared types and constants for the quaternion product / rotate unit.
// No dependencies.
package qpr_pkg;

  typedef enum logic [1:0] {
    REQ_PROD     = 2'd0,
    REQ_ROT_VEC  = 2'd1,
    REQ_ROT_QUAT = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  // Queue status seen by the front end and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Saturation flags of one quaternion product: scalar part and vector part
  typedef struct packed {
    logic sat_w;
    logic sat_v;
  } qmul_sat_t;

  // Component slots in a queued item; slot k sits at bits [k*COMP_WIDTH +: COMP_WIDTH]
  localparam int unsigned F_AW   = 0;
  localparam int unsigned F_AX   = 1;
  localparam int unsigned F_AY   = 2;
  localparam int unsigned F_AZ   = 3;
  localparam int unsigned F_BW   = 4;
  localparam int unsigned F_BX   = 5;
  localparam int unsigned F_BY   = 6;
  localparam int unsigned F_BZ   = 7;
  localparam int unsigned F_CX   = 8;
  localparam int unsigned F_CY   = 9;
  localparam int unsigned F_CZ   = 10;
  localparam int unsigned N_COMP = 11;
  localparam int unsigned REQ_W  = 2;

endpackage

/* rtl/core/qpr_front.sv */
// Front end: takes commands, classifies them and builds the conjugate of a.
// Depends on qpr_pkg.
module qpr_front #(
  parameter int unsigned CW     = 16,
  parameter int unsigned ITEM_W = 3 + 11 * 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic signed [CW-1:0]  a_w,
  input  logic signed [CW-1:0]  a_x,
  input  logic signed [CW-1:0]  a_y,
  input  logic signed [CW-1:0]  a_z,
  input  logic signed [CW-1:0]  b_w,
  input  logic signed [CW-1:0]  b_x,
  input  logic signed [CW-1:0]  b_y,
  input  logic signed [CW-1:0]  b_z,
  input  qpr_pkg::q_stat_t      q_stat,
  output logic                  push,
  output logic [ITEM_W-1:0]     item
);
  import qpr_pkg::*;

  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  logic              held;
  logic              held_next;
  logic              load;
  logic [ITEM_W-1:0] item_next;
  req_t              req;
  logic [CW-1:0]     avec [3];
  logic [CW-1:0]     conj [3];
  logic [2:0]        neg_sat;
  logic              rot;

  assign busy = held && q_stat.full;
  assign push = held && !q_stat.full;
  assign load = start && !busy;

  always_comb begin
    req     = req_t'(req_type);
    rot     = (req == REQ_ROT_VEC) || (req == REQ_ROT_QUAT);
    avec[0] = a_x;
    avec[1] = a_y;
    avec[2] = a_z;
    for (int i = 0; i < 3; i++) begin
      // negating the most negative value clips
      neg_sat[i] = (avec[i] == CMIN);
      conj[i]    = neg_sat[i] ? CMAX : (~avec[i] + 1'b1);
    end
    item_next = '0;
    item_next[F_AW*CW +: CW] = a_w;
    item_next[F_AX*CW +: CW] = a_x;
    item_next[F_AY*CW +: CW] = a_y;
    item_next[F_AZ*CW +: CW] = a_z;
    item_next[F_BW*CW +: CW] = (req == REQ_ROT_VEC) ? '0 : b_w;
    item_next[F_BX*CW +: CW] = b_x;
    item_next[F_BY*CW +: CW] = b_y;
    item_next[F_BZ*CW +: CW] = b_z;
    item_next[F_CX*CW +: CW] = conj[0];
    item_next[F_CY*CW +: CW] = conj[1];
    item_next[F_CZ*CW +: CW] = conj[2];
    item_next[N_COMP*CW]     = rot && (|neg_sat);
    item_next[N_COMP*CW+1 +: REQ_W] = req;
  end

  always_comb begin
    held_next = held;
    if (load) begin
      held_next = 1'b1;
    end else if (push) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

/* rtl/core/qpr_queue.sv */
// Short FIFO between the front end and the back end.
// Depends on qpr_pkg.
module qpr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output qpr_pkg::q_stat_t stat
);
  import qpr_pkg::*;

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNTW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/qpr_qmul.sv */
// Three-stage quaternion product r*l: multiply, sum with rounding bias,
// shift and saturate. Carries a sideband alongside. Depends on qpr_pkg.
module qpr_qmul #(
  parameter int unsigned CW  = 16,
  parameter int unsigned FB  = 14,
  parameter int unsigned SBW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] l_w,
  input  logic signed [CW-1:0] l_x,
  input  logic signed [CW-1:0] l_y,
  input  logic signed [CW-1:0] l_z,
  input  logic signed [CW-1:0] r_w,
  input  logic signed [CW-1:0] r_x,
  input  logic signed [CW-1:0] r_y,
  input  logic signed [CW-1:0] r_z,
  input  logic [SBW-1:0]       sb_in,
  output logic                 out_valid,
  output logic signed [CW-1:0] p_w,
  output logic signed [CW-1:0] p_x,
  output logic signed [CW-1:0] p_y,
  output logic signed [CW-1:0] p_z,
  output qpr_pkg::qmul_sat_t   sat,
  output logic [SBW-1:0]       sb_out
);
  import qpr_pkg::*;

  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = 2 * CW + 2;
  localparam logic signed [SW-1:0] RND  = SW'(1) << (FB - 1);
  localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic                 v1, v2, v3;
  logic [SBW-1:0]       sb1, sb2;
  logic signed [PW-1:0] pr [4][4];
  logic signed [SW-1:0] sum_next [4];
  logic signed [SW-1:0] sum [4];
  logic signed [SW-1:0] sh [4];
  logic signed [CW-1:0] res_next [4];
  logic [3:0]           clip;

  // stage 1: sixteen products
  always_ff @(posedge clk) begin
    pr[0][0] <= l_w * r_w;
    pr[0][1] <= l_x * r_x;
    pr[0][2] <= l_y * r_y;
    pr[0][3] <= l_z * r_z;
    pr[1][0] <= l_w * r_x;
    pr[1][1] <= r_w * l_x;
    pr[1][2] <= l_y * r_z;
    pr[1][3] <= l_z * r_y;
    pr[2][0] <= l_w * r_y;
    pr[2][1] <= r_w * l_y;
    pr[2][2] <= l_z * r_x;
    pr[2][3] <= l_x * r_z;
    pr[3][0] <= l_w * r_z;
    pr[3][1] <= r_w * l_z;
    pr[3][2] <= l_x * r_y;
    pr[3][3] <= l_y * r_x;
    sb1      <= sb_in;
  end

  // stage 2: exact sums plus half an LSB; cross term is subtracted
  always_comb begin
    sum_next[0] = SW'(pr[0][0]) - SW'(pr[0][1]) - SW'(pr[0][2]) - SW'(pr[0][3]) + RND;
    for (int k = 1; k < 4; k++) begin
      sum_next[k] = SW'(pr[k][0]) + SW'(pr[k][1]) - SW'(pr[k][2]) + SW'(pr[k][3]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sum[k] <= sum_next[k];
    end
    sb2 <= sb1;
  end

  // stage 3: drop fraction, clip to component range
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sh[k] = sum[k] >>> FB;
      if (sh[k] > MAXV) begin
        res_next[k] = MAXV[CW-1:0];
        clip[k]     = 1'b1;
      end else if (sh[k] < MINV) begin
        res_next[k] = MINV[CW-1:0];
        clip[k]     = 1'b1;
      end else begin
        res_next[k] = sh[k][CW-1:0];
        clip[k]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_w       <= res_next[0];
    p_x       <= res_next[1];
    p_y       <= res_next[2];
    p_z       <= res_next[3];
    sat.sat_w <= clip[0];
    sat.sat_v <= |clip[3:1];
    sb_out    <= sb2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;

endmodule

/* rtl/core/qpr_back.sv */
// Back end: drains the queue into two chained product pipelines (b*a, then conj(a)
// times that) and registers the selected result. Depends on qpr_pkg, qpr_qmul.
module qpr_back #(
  parameter int unsigned CW     = 16,
  parameter int unsigned FB     = 14,
  parameter int unsigned ITEM_W = 3 + 11 * 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qpr_pkg::q_stat_t     q_stat,
  input  logic [ITEM_W-1:0]    item,
  output logic                 pop,
  output logic                 done,
  output logic signed [CW-1:0] out_w,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z,
  output logic                 saturated
);
  import qpr_pkg::*;

  localparam int unsigned SB1_W = REQ_W + 1 + 4 * CW;
  localparam int unsigned SB2_W = REQ_W + 1 + 2 + 4 * CW;

  logic signed [CW-1:0] comp [N_COMP];
  logic [SB1_W-1:0]     sb1_in, sb1_out;
  logic [SB2_W-1:0]     sb2_in, sb2_out;
  logic                 v1, v2;
  logic signed [CW-1:0] q1_w, q1_x, q1_y, q1_z;
  logic signed [CW-1:0] q2_w, q2_x, q2_y, q2_z;
  qmul_sat_t            s1, s2, s1_d;
  logic                 satc_d;
  logic [REQ_W-1:0]     req_d;
  logic signed [CW-1:0] r1_w, r1_x, r1_y, r1_z;
  logic signed [CW-1:0] c_w, c_x, c_y, c_z;
  logic                 satc_1;
  logic [REQ_W-1:0]     req_1;
  logic signed [CW-1:0] res_next [4];
  logic                 sat_next;

  // the receiver never stalls, so the back end drains one item a cycle
  assign pop = !q_stat.empty;

  always_comb begin
    for (int k = 0; k < N_COMP; k++) begin
      comp[k] = item[k*CW +: CW];
    end
  end

  assign sb1_in = {item[N_COMP*CW+1 +: REQ_W], item[N_COMP*CW],
                   comp[F_AW], comp[F_CX], comp[F_CY], comp[F_CZ]};

  qpr_qmul #(.CW(CW), .FB(FB), .SBW(SB1_W)) u_mul_ab (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop),
    .l_w       (comp[F_AW]),
    .l_x       (comp[F_AX]),
    .l_y       (comp[F_AY]),
    .l_z       (comp[F_AZ]),
    .r_w       (comp[F_BW]),
    .r_x       (comp[F_BX]),
    .r_y       (comp[F_BY]),
    .r_z       (comp[F_BZ]),
    .sb_in     (sb1_in),
    .out_valid (v1),
    .p_w       (q1_w),
    .p_x       (q1_x),
    .p_y       (q1_y),
    .p_z       (q1_z),
    .sat       (s1),
    .sb_out    (sb1_out)
  );

  assign {req_1, satc_1, c_w, c_x, c_y, c_z} = sb1_out;
  assign sb2_in = {req_1, satc_1, s1, q1_w, q1_x, q1_y, q1_z};

  qpr_qmul #(.CW(CW), .FB(FB), .SBW(SB2_W)) u_mul_conj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .l_w       (q1_w),
    .l_x       (q1_x),
    .l_y       (q1_y),
    .l_z       (q1_z),
    .r_w       (c_w),
    .r_x       (c_x),
    .r_y       (c_y),
    .r_z       (c_z),
    .sb_in     (sb2_in),
    .out_valid (v2),
    .p_w       (q2_w),
    .p_x       (q2_x),
    .p_y       (q2_y),
    .p_z       (q2_z),
    .sat       (s2),
    .sb_out    (sb2_out)
  );

  assign {req_d, satc_d, s1_d, r1_w, r1_x, r1_y, r1_z} = sb2_out;

  always_comb begin
    case (req_d)
      REQ_PROD: begin
        res_next[0] = r1_w;
        res_next[1] = r1_x;
        res_next[2] = r1_y;
        res_next[3] = r1_z;
        sat_next    = s1_d.sat_w | s1_d.sat_v;
      end
      REQ_ROT_VEC: begin
        // scalar part of the second product is dropped and never flags
        res_next[0] = '0;
        res_next[1] = q2_x;
        res_next[2] = q2_y;
        res_next[3] = q2_z;
        sat_next    = satc_d | s1_d.sat_w | s1_d.sat_v | s2.sat_v;
      end
      REQ_ROT_QUAT: begin
        res_next[0] = q2_w;
        res_next[1] = q2_x;
        res_next[2] = q2_y;
        res_next[3] = q2_z;
        sat_next    = satc_d | s1_d.sat_w | s1_d.sat_v | s2.sat_w | s2.sat_v;
      end
      default: begin
        res_next[0] = '0;
        res_next[1] = '0;
        res_next[2] = '0;
        res_next[3] = '0;
        sat_next    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_w     <= res_next[0];
    out_x     <= res_next[1];
    out_y     <= res_next[2];
    out_z     <= res_next[3];
    saturated <= sat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

endmodule

/* rtl/core/quaternion_product_rotate_unit.sv */
// Quaternion product / rotation unit, signed fixed point.
// Commands pass the front register, queue, both product pipelines and output register.
// Throughput: one command per cycle; the two product pipelines and the
// output register take a new item every cycle, busy only rises if the queue fills.
// Reset (rst, synchronous) empties the front register, queue and pipelines; done is low.
// Results are shown for one cycle with done; the receiver cannot stall.
module quaternion_product_rotate_unit #(
  parameter int unsigned FRAC_BITS   = 14,
  parameter int unsigned COMP_WIDTH  = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic signed [COMP_WIDTH-1:0] a_w,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] b_w,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  output logic                         done,
  output logic signed [COMP_WIDTH-1:0] out_w,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic                         saturated
);
  import qpr_pkg::*;

  localparam int unsigned ITEM_W = REQ_W + 1 + N_COMP * COMP_WIDTH;

  q_stat_t           q_stat;
  logic              push;
  logic              pop;
  logic [ITEM_W-1:0] front_item;
  logic [ITEM_W-1:0] head_item;

  qpr_front #(.CW(COMP_WIDTH), .ITEM_W(ITEM_W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .a_w      (a_w),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_w      (b_w),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .q_stat   (q_stat),
    .push     (push),
    .item     (front_item)
  );

  qpr_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_item),
    .pop     (pop),
    .rd_data (head_item),
    .stat    (q_stat)
  );

  qpr_back #(.CW(COMP_WIDTH), .FB(FRAC_BITS), .ITEM_W(ITEM_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .item      (head_item),
    .pop       (pop),
    .done      (done),
    .out_w     (out_w),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
  );

endmodule
